// ----- hdl/cbe_pkg.sv -----
`default_nettype none
package cbe_pkg;

    localparam int FB = 15;
    localparam logic signed [23:0] QONE = 24'sd32768;

    localparam logic [2:0] MODE_LINEAR      = 3'd0;
    localparam logic [2:0] MODE_EASE        = 3'd1;
    localparam logic [2:0] MODE_EASE_IN     = 3'd2;
    localparam logic [2:0] MODE_EASE_OUT    = 3'd3;
    localparam logic [2:0] MODE_EASE_IN_OUT = 3'd4;
    localparam logic [2:0] MODE_CUSTOM      = 3'd5;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_X1   = 3'd1;
    localparam logic [2:0] REG_Y1   = 3'd2;
    localparam logic [2:0] REG_X2   = 3'd3;
    localparam logic [2:0] REG_Y2   = 3'd4;

    // preset control points, rounded to nearest at q.15
    localparam logic signed [23:0] Q_0P25 = 24'sd8192;
    localparam logic signed [23:0] Q_0P10 = 24'sd3277;
    localparam logic signed [23:0] Q_0P42 = 24'sd13763;
    localparam logic signed [23:0] Q_0P58 = 24'sd19005;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_MUL, ST_SEQ, ST_DIV, ST_UPD, ST_OUT
    } t_state;

    // round-to-nearest q product, ties away from zero
    function automatic logic signed [23:0] rnd_q(input logic signed [47:0] p);
        logic [47:0] a;
        logic [47:0] r;
        begin
            a = p[47] ? 48'(-p) : 48'(p);
            r = (a + 48'(1 << (FB - 1))) >> FB;
            rnd_q = p[47] ? -24'(r) : 24'(r);
        end
    endfunction

endpackage
`default_nettype wire

// ----- hdl/cbe_if.sv -----
`default_nettype none
interface cbe_stream_if #(parameter int W = 17);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cbe_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [17:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/cubic_bezier_easing_core.sv -----
`default_nettype none
// channel   dir   payload          handshake
// cfg       in    index[2:0],data  valid/ready, ready always high
// t         in    t_in  s17 q.15   valid/ready
// y         out   y_out s18 q.15   valid/ready, one result per item
//
// one item at a time through a single 24x24 multiplier and a restoring radix-2 divider
// an end point or the identity curve: ST_SETUP goes straight to ST_OUT, with no iteration
// each newton step: x multiplies, a decision, dx multiplies, a decision, a divide and an update
// the final y evaluation reuses the multiplier, then ST_OUT registers the result;
// iteration stops after NEWTON_STEPS steps, or earlier on zero error or a flat derivative
// reset restores the register defaults and empties the result register
// while a result waits unreturned, no new item is taken
module cubic_bezier_easing_core
    import cbe_pkg::*;
#(
    parameter int NEWTON_STEPS = 8
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    cbe_cfg_if.sink    cfg,
    cbe_stream_if.sink t_in_ch,
    cbe_stream_if.source y_out_ch
);

    localparam int IW = $clog2(NEWTON_STEPS + 1);

    logic [2:0]         r_mode;
    logic [15:0]        r_cx1, r_cx2;
    logic signed [17:0] r_cy1, r_cy2;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LINEAR;
            r_cx1  <= 16'd8192;
            r_cy1  <= 18'sd3277;
            r_cx2  <= 16'd8192;
            r_cy2  <= 18'sd32768;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                REG_MODE: r_mode <= cfg.data[2:0];
                REG_X1:   r_cx1  <= cfg.data[15:0];
                REG_Y1:   r_cy1  <= cfg.data;
                REG_X2:   r_cx2  <= cfg.data[15:0];
                REG_Y2:   r_cy2  <= cfg.data;
                default: ;
            endcase
        end
    end

    t_state r_st, n_st;
    logic signed [23:0] r_t, r_s, r_x1, r_y1, r_x2, r_y2;
    logic signed [23:0] r_acc;           // x or y accumulator
    logic signed [23:0] r_dx;            // derivative accumulator
    logic signed [23:0] r_s2, r_om2, r_os, r_tmp;
    logic [3:0]         r_op;            // multiply sequence step
    logic               r_final;         // evaluating y rather than x
    logic [IW-1:0]      r_it;
    logic signed [17:0] r_y;
    logic               r_yv;
    // divider
    logic [39:0]        r_num;
    logic [23:0]        r_den;
    logic [40:0]        r_rem;
    logic [39:0]        r_quo;
    logic [5:0]         r_dcnt;
    logic               r_neg;

    logic signed [23:0] ma, mb;
    logic signed [47:0] mp;
    logic signed [23:0] mq, om;
    assign om = QONE - r_s;

    // operand selection for the shared multiplier
    always_comb begin
        ma = r_s;
        mb = r_s;
        case (r_op)
            4'd0: begin ma = r_s;   mb = r_s;   end          // s2
            4'd1: begin ma = r_s2;  mb = r_s;   end          // s3
            4'd2: begin ma = om;    mb = om;    end          // om2
            4'd3: begin ma = r_om2; mb = r_s;   end          // b1/3
            4'd4: begin ma = om;    mb = r_s2;  end          // b2/3
            4'd5: begin ma = r_tmp; mb = r_final ? r_y1 : r_x1; end
            4'd6: begin ma = r_tmp; mb = r_final ? r_y2 : r_x2; end
            4'd7: begin ma = r_om2; mb = r_x1;  end
            4'd8: begin ma = om;    mb = r_s;   end
            4'd9: begin ma = r_os;  mb = r_x2 - r_x1; end
            4'd10: begin ma = r_s2; mb = QONE - r_x2; end
            default: ;
        endcase
    end
    assign mp = ma * mb;
    assign mq = rnd_q(mp);

    logic signed [23:0] b1s, b2s;   // bernstein weights from the product
    logic signed [23:0] r_b2;
    assign b1s = 24'(3) * mq;
    assign b2s = 24'(3) * mq;

    logic signed [23:0] tc;
    logic signed [16:0] tin;
    assign tin = t_in_ch.data;
    assign tc = (tin < 0) ? 24'sd0 : ((24'(tin) > QONE) ? QONE : 24'(tin));

    logic signed [23:0] err;
    assign err = r_acc - r_t;

    // newton update, wide enough for a quotient from a tiny derivative
    logic signed [41:0] qs, sd;
    logic signed [23:0] sn;
    assign qs = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign sd = 42'(r_s) - qs;
    assign sn = (sd < 0) ? 24'sd0 : ((sd > 42'(QONE)) ? QONE : 24'(sd));

    logic [40:0] dsub;
    assign dsub = {r_rem[39:0], r_num[39]} - {17'd0, r_den};

    logic signed [23:0] yc;
    assign yc = (r_acc < -24'sd65536) ? -24'sd65536 :
                ((r_acc > 24'sd131071) ? 24'sd131071 : r_acc);

    assign t_in_ch.ready  = (r_st == ST_IDLE) && !r_yv;
    assign y_out_ch.valid = r_yv;
    assign y_out_ch.data  = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (t_in_ch.valid && !r_yv) n_st = ST_SETUP;
            ST_SETUP: begin
                if (r_t <= 0 || r_t >= QONE || (r_x1 == r_y1 && r_x2 == r_y2))
                    n_st = ST_OUT;
                else
                    n_st = ST_MUL;
            end
            ST_MUL: begin
                if (r_op == 4'd6)       n_st = r_final ? ST_OUT : ST_SEQ;
                else if (r_op == 4'd10) n_st = ST_SEQ;
            end
            ST_SEQ: begin
                if (r_op == 4'd10 && r_dx != 0) n_st = ST_DIV;
                else                            n_st = ST_MUL;
            end
            ST_DIV:   if (r_dcnt == 6'd40) n_st = ST_UPD;
            ST_UPD:   n_st = ST_MUL;
            ST_OUT:   n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // datapath; one multiply per ST_MUL cycle, ST_SEQ decides after x and after dx
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yv <= 1'b0;
        end else begin
            if (y_out_ch.valid && y_out_ch.ready) r_yv <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (t_in_ch.valid && !r_yv) begin
                    r_t <= tc;
                    r_s <= tc;
                    r_acc <= tc;
                    r_op <= 4'd0;
                    r_final <= 1'b0;
                    r_it <= '0;
                    unique case (r_mode)
                        MODE_EASE: begin
                            r_x1 <= Q_0P25; r_y1 <= Q_0P10;
                            r_x2 <= Q_0P25; r_y2 <= QONE;
                        end
                        MODE_EASE_IN: begin
                            r_x1 <= Q_0P42; r_y1 <= '0; r_x2 <= QONE; r_y2 <= QONE;
                        end
                        MODE_EASE_OUT: begin
                            r_x1 <= '0; r_y1 <= '0; r_x2 <= Q_0P58; r_y2 <= QONE;
                        end
                        MODE_EASE_IN_OUT: begin
                            r_x1 <= Q_0P42; r_y1 <= '0; r_x2 <= Q_0P58; r_y2 <= QONE;
                        end
                        MODE_CUSTOM: begin
                            r_x1 <= (r_cx1 > 16'd32768) ? QONE : 24'(r_cx1);
                            r_x2 <= (r_cx2 > 16'd32768) ? QONE : 24'(r_cx2);
                            r_y1 <= 24'(r_cy1);
                            r_y2 <= 24'(r_cy2);
                        end
                        default: begin
                            r_x1 <= '0; r_y1 <= '0; r_x2 <= '0; r_y2 <= '0;
                        end
                    endcase
                end
                ST_SETUP: begin
                    if (r_t <= 0) r_acc <= '0;
                    else if (r_t >= QONE) r_acc <= QONE;
                end
                ST_MUL: begin
                    case (r_op)
                        4'd0: r_s2 <= mq;
                        4'd1: r_acc <= mq;
                        4'd2: r_om2 <= mq;
                        4'd3: r_tmp <= b1s;
                        4'd4: r_b2 <= b2s;
                        4'd5: begin r_acc <= r_acc + mq; r_tmp <= r_b2; end
                        4'd6: r_acc <= r_acc + mq;
                        4'd7: r_dx <= 24'(3) * mq;
                        4'd8: r_os <= mq;
                        4'd9: r_dx <= r_dx + 24'(6) * mq;
                        4'd10: r_dx <= r_dx + 24'(3) * mq;
                        default: ;
                    endcase
                    // steps 6 and 10 hand over to the sequencer, step 6 to ST_OUT when final
                    if (r_op != 4'd6 && r_op != 4'd10) r_op <= r_op + 4'd1;
                end
                ST_SEQ: begin
                    if (r_op == 4'd6) begin
                        // converged: evaluate y at the current point
                        if (err == 0) begin
                            r_final <= 1'b1; r_op <= 4'd0;
                        end else begin
                            r_op <= 4'd7;
                        end
                    end else if (r_dx == 0) begin
                        // flat derivative: stop iterating
                        r_final <= 1'b1; r_op <= 4'd0;
                    end else begin
                        r_neg <= (err < 0) != (r_dx < 0);
                        r_num <= 40'((err < 0 ? -err : err)) << FB;
                        r_den <= r_dx < 0 ? -r_dx : r_dx;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_dcnt <= '0;
                    end
                end
                ST_DIV: begin
                    if (r_dcnt == 6'd40) begin
                        // round to nearest: compare remainder against half divisor
                        if ({r_rem[39:0], 1'b0} >= {17'd0, r_den})
                            r_quo <= r_quo + 40'd1;
                    end else begin
                        if (!dsub[40]) begin
                            r_rem <= dsub;
                            r_quo <= {r_quo[38:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[39:0], r_num[39]};
                            r_quo <= {r_quo[38:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_dcnt <= r_dcnt + 6'd1;
                    end
                end
                ST_UPD: begin
                    r_s <= sn;
                    r_op <= 4'd0;
                    r_it <= r_it + IW'(1);
                    if (r_it + IW'(1) == IW'(NEWTON_STEPS)) r_final <= 1'b1;
                end
                ST_OUT: begin
                    r_y <= 18'(yc);
                    r_yv <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT) |=> r_yv)
        else $error("result not registered");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_in_ch.ready |-> !r_yv)
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_UPD) |-> (sn >= 0 && sn <= QONE))
        else $error("newton point out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV) |-> !r_final)
        else $error("divide during final evaluation");

endmodule
`default_nettype wire

// ----- verif/cubic_bezier_easing_checker.sv -----
`timescale 1ns / 1ps
module cubic_bezier_easing_checker
    import cbe_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [17:0] i_cfg_data,
    input  wire        i_t_valid,
    input  wire        i_t_ready,
    input  wire [16:0] i_t_data,
    input  wire        i_y_valid,
    input  wire        i_y_ready,
    input  wire [17:0] i_y_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam longint ONE = 64'sd32768;

    logic [2:0]  mode_r;
    logic [15:0] x1_r, x2_r;
    logic [17:0] y1_r, y2_r;
    logic [17:0] eased_q[$];

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0) return (p + 16384) >>> 15;
        return -((-p + 16384) >>> 15);
    endfunction

    function automatic longint qdiv(longint num, longint den);
        longint n, d, q;
        n = (num < 0 ? -num : num) * ONE;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic longint lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint curve_y(longint t, longint x1, longint y1,
                                       longint x2, longint y2);
        longint s, s2, s3, om, om2, b1, b2, x, err, dx;
        s = t;
        if (t <= 0) return 0;
        if (t >= ONE) return ONE;
        if (x1 == y1 && x2 == y2) return t;
        for (int i = 0; i < 8; i++) begin
            s2 = qmul(s, s); s3 = qmul(s2, s); om = ONE - s; om2 = qmul(om, om);
            b1 = 3 * qmul(om2, s); b2 = 3 * qmul(om, s2);
            x = qmul(b1, x1) + qmul(b2, x2) + s3;
            err = x - t;
            if (err == 0) break;
            dx = 3 * qmul(om2, x1) + 6 * qmul(qmul(om, s), x2 - x1)
               + 3 * qmul(s2, ONE - x2);
            if (dx == 0) break;
            s = lim(s - qdiv(err, dx), 0, ONE);
        end
        s2 = qmul(s, s); s3 = qmul(s2, s); om = ONE - s; om2 = qmul(om, om);
        b1 = 3 * qmul(om2, s); b2 = 3 * qmul(om, s2);
        return qmul(b1, y1) + qmul(b2, y2) + s3;
    endfunction

    function automatic logic [17:0] eased_value(logic [16:0] tin);
        longint t, y;
        t = lim(longint'($signed(tin)), 0, ONE);
        case (mode_r)
            MODE_EASE:        y = curve_y(t, 8192, 3277, 8192, ONE);
            MODE_EASE_IN:     y = curve_y(t, 13763, 0, ONE, ONE);
            MODE_EASE_OUT:    y = curve_y(t, 0, 0, 19005, ONE);
            MODE_EASE_IN_OUT: y = curve_y(t, 13763, 0, 19005, ONE);
            MODE_CUSTOM:      y = curve_y(t, lim(longint'(x1_r), 0, ONE),
                                      longint'($signed(y1_r)),
                                      lim(longint'(x2_r), 0, ONE),
                                      longint'($signed(y2_r)));
            default:          y = t;
        endcase
        y = lim(y, -65536, 131071);
        return y[17:0];
    endfunction

    assign o_pending = eased_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_r <= MODE_LINEAR; x1_r <= 16'd8192; y1_r <= 18'd3277;
            x2_r <= 16'd8192; y2_r <= 18'd32768;
            eased_q.delete();
            o_fail_count <= 0;
        end else begin
            // results first: prediction uses config of the item's own transfer
            if (i_y_valid && i_y_ready) begin
                if (eased_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, $signed(i_y_data));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (eased_q[0] !== i_y_data) begin
                        $display("%0t: y_out mismatch, expected %0d, actual %0d",
                                 $time, $signed(eased_q[0]), $signed(i_y_data));
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(eased_q.pop_front());
                end
            end
            if (i_t_valid && i_t_ready) eased_q.push_back(eased_value(i_t_data));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE: mode_r <= i_cfg_data[2:0];
                    REG_X1:   x1_r <= i_cfg_data[15:0];
                    REG_Y1:   y1_r <= i_cfg_data;
                    REG_X2:   x2_r <= i_cfg_data[15:0];
                    REG_Y2:   y2_r <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- verif/cubic_bezier_easing_core_test.sv -----
`timescale 1ns / 1ps
module cubic_bezier_easing_core_test;
    import cbe_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   calm;          // no idling in the last part of the run

    cbe_cfg_if            cfg_ch ();
    cbe_stream_if #(17)   t_ch ();
    cbe_stream_if #(18)   y_ch ();

    cubic_bezier_easing_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .cfg      (cfg_ch),
        .t_in_ch  (t_ch),
        .y_out_ch (y_ch)
    );

    cubic_bezier_easing_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_index  (cfg_ch.index),
        .i_cfg_data   (cfg_ch.data),
        .i_t_valid    (t_ch.valid),
        .i_t_ready    (t_ch.ready),
        .i_t_data     (t_ch.data),
        .i_y_valid    (y_ch.valid),
        .i_y_ready    (y_ch.ready),
        .i_y_data     (y_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall: random bursts of low ready, none once calm
    initial begin
        int n;
        y_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                y_ch.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                y_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((t_ch.valid && t_ch.ready) || (y_ch.valid && y_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("cubic_bezier_easing_core_test failed");
            $finish;
        end
    end

    // one config transfer, block idle, then valid drops
    task automatic write_reg(logic [2:0] index, logic [17:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold valid until the transfer; optional sender gap afterwards
    task automatic send_t(logic [16:0] value);
        t_ch.valid <= 1'b1;
        t_ch.data  <= value;
        do @(posedge i_clk); while (!t_ch.ready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            t_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        t_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // mostly the useful 0..1 range, sometimes anything in the field
    function automatic logic [16:0] pick_t();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom);
            1:       return 17'($urandom_range(0, 3));
            2:       return 17'(32768 - $urandom_range(0, 3));
            default: return 17'($urandom_range(1, 32767));
        endcase
    endfunction

    task automatic random_custom;
        logic [15:0] x1, x2;
        logic [17:0] y1, y2;
        x1 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        x2 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        y1 = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(0, 32768));
        y2 = ($urandom_range(0, 3) == 0) ? 18'($urandom) : 18'($urandom_range(0, 32768));
        if ($urandom_range(0, 9) == 0) begin
            y1 = 18'(x1); y2 = 18'(x2);     // identity curve
        end
        write_reg(REG_MODE, 18'(MODE_CUSTOM));
        write_reg(REG_X1, 18'(x1));
        write_reg(REG_Y1, y1);
        write_reg(REG_X2, 18'(x2));
        write_reg(REG_Y2, y2);
    endtask

    initial begin
        logic [16:0] edge_t[12];
        calm = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        t_ch.valid = 1'b0;   t_ch.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and end points, reset config first
        edge_t = '{17'h10000, 17'h1FFFF, 17'd0, 17'd1, 17'd16384, 17'd32767,
                   17'd32768, 17'd32769, 17'hFFFF, 17'h0AAAA, 17'h15555, 17'd100};
        foreach (edge_t[i]) send_t(edge_t[i]);
        drain();
        // each mode, the unused ones too
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_MODE, 18'(m));
            send_t(17'd8000);
            send_t(17'd25000);
            drain();
        end
        // custom extremes: large y saturates, x beyond one is clamped, all bits set
        write_reg(REG_MODE, 18'(MODE_CUSTOM));
        write_reg(REG_X1, 18'hFFFF);
        write_reg(REG_Y1, 18'h1FFFF);
        write_reg(REG_X2, 18'd0);
        write_reg(REG_Y2, 18'h20000);
        write_reg(REG_UNUSED, 18'h3FFFF);    // out-of-range index, ignored
        send_t(17'd16384); send_t(17'd3000); send_t(17'd30000);
        drain();

        // random phases over modes and custom curves
        for (int p = 0; p < 34; p++) begin
            if (p == 29) calm = 1'b1;
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_MODE, 18'($urandom_range(0, 7)));
            else
                random_custom();
            repeat (30) send_t(pick_t());
            drain();                        // sender waits for every result
        end

        drain();
        if (fail_count == 0) begin
            $display("cubic_bezier_easing_core_test passed");
        end else begin
            $display("cubic_bezier_easing_core_test failed");
        end
        $finish;
    end

endmodule

// ----- cubic_bezier_easing_core.f -----
hdl/cbe_pkg.sv
hdl/cbe_if.sv
hdl/cubic_bezier_easing_core.sv
verif/cubic_bezier_easing_checker.sv
verif/cubic_bezier_easing_core_test.sv
